// ----- design/qpt_pkg.sv -----
// ----------------------------------------------------------------------------
// qpt_pkg
// shared types and codes for the quaternion pose point transform
// ----------------------------------------------------------------------------
package qpt_pkg;

    localparam int CoordW = 32;
    localparam int NumRegs = 7;

    // request kinds
    localparam logic [1:0] REQ_PT_WORLD   = 2'd0;
    localparam logic [1:0] REQ_VEC_WORLD  = 2'd1;
    localparam logic [1:0] REQ_PT_SENSOR  = 2'd2;
    localparam logic [1:0] REQ_VEC_SENSOR = 2'd3;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    // register indexes
    localparam logic [2:0] REG_ROT_W   = 3'd0;
    localparam logic [2:0] REG_ROT_X   = 3'd1;
    localparam logic [2:0] REG_ROT_Y   = 3'd2;
    localparam logic [2:0] REG_ROT_Z   = 3'd3;
    localparam logic [2:0] REG_SHIFT_X = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y = 3'd5;
    localparam logic [2:0] REG_SHIFT_Z = 3'd6;

    localparam logic [31:0] ROT_ONE = 32'h4000_0000;

    typedef struct packed {
        logic                   ready;
        logic                   invalid;
        logic [8:0][CoordW-1:0] mat;
        logic [2:0][CoordW-1:0] shift;
    } t_pose;

endpackage

// ----- design/qpt_pose.sv -----
// ----------------------------------------------------------------------------
// qpt_pose
// pose registers and sequencer that builds the normalised rotation matrix
// ----------------------------------------------------------------------------
module qpt_pose import qpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [CoordW-1:0] i_cfg_data,
    output t_pose             o_pose
);

    typedef enum logic [3:0] {
        S_MUL  = 4'b0001,
        S_NORM = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state              r_state;
    logic [3:0][31:0]    r_rot;
    logic [2:0][31:0]    r_shift;
    logic [9:0][63:0]    r_prod;
    logic [64:0]         r_sum;
    logic [3:0]          r_idx;
    logic [63:0]         r_nr;
    logic [5:0]          r_s;
    logic [3:0]          r_ent;
    logic                r_ld;
    logic [5:0]          r_cnt;
    logic [31:0]         r_rem;
    logic [63:0]         r_quo;
    logic                r_neg;
    logic [8:0][31:0]    r_mat;

    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic signed [63:0]  num, scaled, mag;
    logic [63:0]         n_sum4;
    logic [31:0]         div_t;
    logic                div_ge;
    logic [31:0]         n_rem;
    logic [63:0]         n_quo;
    logic [31:0]         q_clamp;

    // operand pairs: squares first, then cross terms
    always_comb begin
        unique case (r_idx)
            4'd0: begin mul_a = r_rot[0]; mul_b = r_rot[0]; end
            4'd1: begin mul_a = r_rot[1]; mul_b = r_rot[1]; end
            4'd2: begin mul_a = r_rot[2]; mul_b = r_rot[2]; end
            4'd3: begin mul_a = r_rot[3]; mul_b = r_rot[3]; end
            4'd4: begin mul_a = r_rot[1]; mul_b = r_rot[2]; end
            4'd5: begin mul_a = r_rot[1]; mul_b = r_rot[3]; end
            4'd6: begin mul_a = r_rot[2]; mul_b = r_rot[3]; end
            4'd7: begin mul_a = r_rot[0]; mul_b = r_rot[1]; end
            4'd8: begin mul_a = r_rot[0]; mul_b = r_rot[2]; end
            4'd9: begin mul_a = r_rot[0]; mul_b = r_rot[3]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign n_sum4 = r_prod[0] + r_prod[1] + r_prod[2] + r_prod[3];

    // matrix numerators from the floored products
    always_comb begin
        unique case (r_ent)
            4'd0: num = r_prod[0] + r_prod[1] - r_prod[2] - r_prod[3];
            4'd1: num = (r_prod[4] - r_prod[9]) <<< 1;
            4'd2: num = (r_prod[5] + r_prod[8]) <<< 1;
            4'd3: num = (r_prod[4] + r_prod[9]) <<< 1;
            4'd4: num = r_prod[0] - r_prod[1] + r_prod[2] - r_prod[3];
            4'd5: num = (r_prod[6] - r_prod[7]) <<< 1;
            4'd6: num = (r_prod[5] - r_prod[8]) <<< 1;
            4'd7: num = (r_prod[6] + r_prod[7]) <<< 1;
            4'd8: num = r_prod[0] - r_prod[1] - r_prod[2] + r_prod[3];
            default: num = '0;
        endcase
    end

    assign scaled = (num >>> r_s) <<< 30;
    assign mag    = scaled[63] ? -scaled : scaled;

    // one restoring divide step per cycle
    assign div_t  = {r_rem[30:0], r_quo[63]};
    assign div_ge = div_t >= r_nr[31:0];
    assign n_rem  = div_ge ? div_t - r_nr[31:0] : div_t;
    assign n_quo  = {r_quo[62:0], div_ge};
    assign q_clamp = (n_quo > {32'd0, ROT_ONE}) ? ROT_ONE : n_quo[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_MUL;
            r_rot   <= {32'd0, 32'd0, 32'd0, ROT_ONE};
            r_shift <= '0;
            r_idx   <= '0;
            r_sum   <= '0;
            r_ent   <= '0;
            r_ld    <= 1'b1;
            r_cnt   <= '0;
            r_s     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROT_W:   r_rot[0]   <= i_cfg_data;
                REG_ROT_X:   r_rot[1]   <= i_cfg_data;
                REG_ROT_Y:   r_rot[2]   <= i_cfg_data;
                REG_ROT_Z:   r_rot[3]   <= i_cfg_data;
                REG_SHIFT_X: r_shift[0] <= i_cfg_data;
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data;
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data;
                default: ;
            endcase
            r_state <= S_MUL;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            unique case (r_state)
                S_MUL: begin
                    r_prod[r_idx] <= mul_p >>> 2;
                    if (r_idx < 4'd4) begin
                        r_sum <= r_sum + {1'b0, mul_p};
                    end
                    if (r_idx == 4'd9) begin
                        r_state <= S_NORM;
                        r_nr    <= n_sum4;
                        r_s     <= '0;
                    end else begin
                        r_idx <= r_idx + 4'd1;
                    end
                end
                S_NORM: begin
                    if (r_sum < 65'd1048576) begin
                        r_state <= S_DONE;
                    end else if (r_nr >= 64'h8000_0000) begin
                        r_nr <= r_nr >> 1;
                        r_s  <= r_s + 6'd1;
                    end else begin
                        r_state <= S_DIV;
                        r_ent   <= '0;
                        r_ld    <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_ld) begin
                        r_quo <= mag + (r_nr >> 1);
                        r_rem <= '0;
                        r_neg <= scaled[63];
                        r_cnt <= '0;
                        r_ld  <= 1'b0;
                    end else begin
                        r_quo <= n_quo;
                        r_rem <= n_rem;
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd63) begin
                            r_mat[r_ent] <= r_neg ? -q_clamp : q_clamp;
                            r_ld         <= 1'b1;
                            if (r_ent == 4'd8) begin
                                r_state <= S_DONE;
                            end else begin
                                r_ent <= r_ent + 4'd1;
                            end
                        end
                    end
                end
                S_DONE: ;
                default: r_state <= S_MUL;
            endcase
        end
    end

    assign o_pose.ready   = (r_state == S_DONE);
    assign o_pose.invalid = (r_sum < 65'd1048576);
    assign o_pose.mat     = r_mat;
    assign o_pose.shift   = r_shift;

endmodule

// ----- design/quaternion_pose_point_transform.sv -----
// ----------------------------------------------------------------------------
// quaternion_pose_point_transform
// rigid pose transform of one three-component coordinate per beat
// ----------------------------------------------------------------------------
// Takes one beat per cycle while o_stall is low and registers its result
// through subtract, multiply, sum and round, translate and saturate. The
// normalised rotation matrix is rebuilt by a serial unit after reset and
// after every register write: ten multiplies on one shared multiplier, a
// normalising shift, then, unless the rotation is invalid, nine restoring
// divides; o_stall stays high until the rebuild is done.
module quaternion_pose_point_transform import qpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [CoordW-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_req_type,
    input  logic signed [CoordW-1:0] i_in_x,
    input  logic signed [CoordW-1:0] i_in_y,
    input  logic signed [CoordW-1:0] i_in_z,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [CoordW-1:0] o_out_x,
    output logic signed [CoordW-1:0] o_out_y,
    output logic signed [CoordW-1:0] o_out_z,
    output logic [1:0]        o_status
);

    t_pose pose;

    qpt_pose u_pose (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pose     (pose)
    );

    logic en1, en2, en3, en4, accept;
    logic r1_v, r2_v, r3_v, r4_v;
    logic [1:0] r1_kind, r2_kind, r3_kind;
    logic [2:0][32:0] r1_val;
    logic [2:0][2:0][64:0] r2_prod;
    logic [2:0][37:0] r3_res;
    logic signed [31:0] r4_x, r4_y, r4_z;
    logic [1:0] r4_st;

    logic [2:0][32:0] n_val;
    logic [2:0][2:0][31:0] sel_m;
    logic [2:0][37:0] n_res;
    logic [2:0][38:0] n_fin;
    logic [2:0][31:0] n_sat;
    logic [2:0] sat_hit;

    assign en4    = !r4_v || !i_stall;
    assign en3    = !r3_v || en4;
    assign en2    = !r2_v || en3;
    assign en1    = !r1_v || en2;
    assign o_stall = !en1 || !pose.ready;
    assign accept = i_valid && !o_stall;

    // point to sensor takes p - t at full width
    always_comb begin
        n_val[0] = {i_in_x[31], i_in_x};
        n_val[1] = {i_in_y[31], i_in_y};
        n_val[2] = {i_in_z[31], i_in_z};
        if (i_req_type == REQ_PT_SENSOR) begin
            for (int i = 0; i < 3; i++) begin
                n_val[i] = n_val[i] - {pose.shift[i][31], pose.shift[i]};
            end
        end
    end

    // to sensor uses the transpose
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sel_m[i][j] = r1_kind[1] ? pose.mat[3*j+i] : pose.mat[3*i+j];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_res[i] = 38'(($signed({{2{r2_prod[i][0][64]}}, r2_prod[i][0][64:2]})
                          + $signed({{2{r2_prod[i][1][64]}}, r2_prod[i][1][64:2]})
                          + $signed({{2{r2_prod[i][2][64]}}, r2_prod[i][2][64:2]})
                          + 65'sd134217728) >>> 28);
            n_fin[i] = {r3_res[i][37], r3_res[i]};
            if (r3_kind == REQ_PT_WORLD) begin
                n_fin[i] = n_fin[i] + {{7{pose.shift[i][31]}}, pose.shift[i]};
            end
            if ($signed(n_fin[i]) > 39'sd2147483647) begin
                n_sat[i] = 32'h7fff_ffff;
                sat_hit[i] = 1'b1;
            end else if ($signed(n_fin[i]) < -39'sd2147483648) begin
                n_sat[i] = 32'h8000_0000;
                sat_hit[i] = 1'b1;
            end else begin
                n_sat[i] = n_fin[i][31:0];
                sat_hit[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (en1) r1_v <= accept;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_kind <= i_req_type;
            r1_val  <= n_val;
        end
        if (en2) begin
            r2_kind <= r1_kind;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_prod[i][j] <= $signed(sel_m[i][j]) * $signed(r1_val[j]);
                end
            end
        end
        if (en3) begin
            r3_kind <= r2_kind;
            r3_res  <= n_res;
        end
        if (en4) begin
            if (pose.invalid) begin
                r4_x  <= '0;
                r4_y  <= '0;
                r4_z  <= '0;
                r4_st <= ST_INVALID;
            end else begin
                r4_x  <= n_sat[0];
                r4_y  <= n_sat[1];
                r4_z  <= n_sat[2];
                r4_st <= (|sat_hit) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_valid  = r4_v;
    assign o_out_x  = r4_x;
    assign o_out_y  = r4_y;
    assign o_out_z  = r4_z;
    assign o_status = r4_st;

endmodule

// ----- design/qpt_checker.sv -----
// ----------------------------------------------------------------------------
// qpt_checker
// port-level checks on the quaternion pose point transform
// ----------------------------------------------------------------------------
module qpt_checker import qpt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CoordW-1:0] o_out_x,
    input logic [CoordW-1:0] o_out_y,
    input logic [CoordW-1:0] o_out_z,
    input logic [1:0]        o_status
);

    // a waiting result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_out_z) && $stable(o_status))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_INVALID || o_status == ST_SAT))
        else $error("unknown status code");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_INVALID |-> o_out_x == '0 && o_out_y == '0
            && o_out_z == '0)
        else $error("invalid pose gave a non-zero result");

    // matrix rebuild after a register write holds off input
    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_stall)
        else $error("input taken while pose rebuilds");

endmodule

bind quaternion_pose_point_transform qpt_checker u_qpt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_cfg_we (i_cfg_we),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_out_x  (o_out_x),
    .o_out_y  (o_out_y),
    .o_out_z  (o_out_z),
    .o_status (o_status)
);

// ----- tb/pose_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_checker
// watches the pose registers and both channels, predicts each result beat
// from the current pose and compares it field by field in order
// ----------------------------------------------------------------------------
module pose_checker import qpt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [CoordW-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [1:0]               i_req_type,
    input  logic signed [CoordW-1:0] i_in_x,
    input  logic signed [CoordW-1:0] i_in_y,
    input  logic signed [CoordW-1:0] i_in_z,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [CoordW-1:0] i_out_x,
    input  logic signed [CoordW-1:0] i_out_y,
    input  logic signed [CoordW-1:0] i_out_z,
    input  logic [1:0]               i_status,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic [1:0]               status;
    } t_coord;

    localparam longint QOne    = 64'sd1 << 30;
    localparam longint NormMin = 64'sd1 << 20;
    localparam longint I32Max  = 64'sd2147483647;
    localparam longint I32Min  = -64'sd2147483648;

    logic signed [CoordW-1:0] pose_rot [4];
    logic signed [CoordW-1:0] pose_shift [3];
    t_coord expected_coords [$];

    function automatic longint norm_entry(longint num, int s, longint nr);
        longint a;
        longint mag;
        longint q;
        a = (num >>> s) * QOne;
        mag = (a < 0) ? -a : a;
        if (nr <= 0) return 0;
        q = (mag + nr / 2) / nr;
        if (q > QOne) q = QOne;
        return (a < 0) ? -q : q;
    endfunction

    function automatic longint rot_dot(longint a, longint b, longint c,
                                       longint x, longint y, longint z);
        longint acc;
        acc = ((a * x) >>> 2) + ((b * y) >>> 2) + ((c * z) >>> 2);
        return (acc + (64'sd1 << 27)) >>> 28;
    endfunction

    function automatic t_coord transform_beat(logic [1:0] kind,
                                              longint px, longint py, longint pz);
        longint w, x, y, z, sw, sx, sy, sz;
        longint fw, fx, fy, fz, xy, xz, yz, wx, wy, wz, n, nr;
        longint m [9];
        longint r [3];
        longint t [3];
        int s;
        bit sat;
        t_coord res;
        w = pose_rot[0]; x = pose_rot[1]; y = pose_rot[2]; z = pose_rot[3];
        t[0] = pose_shift[0]; t[1] = pose_shift[1]; t[2] = pose_shift[2];
        sw = w * w; sx = x * x; sy = y * y; sz = z * z;
        // each square checked first so the sum cannot wrap
        if (sw < NormMin && sx < NormMin && sy < NormMin && sz < NormMin &&
            sw + sx + sy + sz < NormMin) begin
            res = '0;
            res.status = ST_INVALID;
            return res;
        end
        fw = sw >>> 2; fx = sx >>> 2; fy = sy >>> 2; fz = sz >>> 2;
        xy = (x * y) >>> 2; xz = (x * z) >>> 2; yz = (y * z) >>> 2;
        wx = (w * x) >>> 2; wy = (w * y) >>> 2; wz = (w * z) >>> 2;
        n = fw + fx + fy + fz;
        s = 0;
        while (s < 40 && (n >>> s) >= (64'sd1 << 31)) s++;
        nr = n >>> s;
        m[0] = norm_entry(fw + fx - fy - fz, s, nr);
        m[1] = norm_entry(2 * (xy - wz), s, nr);
        m[2] = norm_entry(2 * (xz + wy), s, nr);
        m[3] = norm_entry(2 * (xy + wz), s, nr);
        m[4] = norm_entry(fw - fx + fy - fz, s, nr);
        m[5] = norm_entry(2 * (yz - wx), s, nr);
        m[6] = norm_entry(2 * (xz - wy), s, nr);
        m[7] = norm_entry(2 * (yz + wx), s, nr);
        m[8] = norm_entry(fw - fx - fy + fz, s, nr);
        if (kind == REQ_PT_SENSOR || kind == REQ_VEC_SENSOR) begin
            if (kind == REQ_PT_SENSOR) begin
                px -= t[0]; py -= t[1]; pz -= t[2];
            end
            // inverse rotation uses the transposed matrix
            for (int i = 0; i < 3; i++)
                r[i] = rot_dot(m[i], m[3 + i], m[6 + i], px, py, pz);
        end else begin
            for (int i = 0; i < 3; i++)
                r[i] = rot_dot(m[3 * i], m[3 * i + 1], m[3 * i + 2], px, py, pz);
            if (kind == REQ_PT_WORLD)
                for (int i = 0; i < 3; i++) r[i] += t[i];
        end
        sat = 0;
        for (int i = 0; i < 3; i++) begin
            if (r[i] > I32Max) begin r[i] = I32Max; sat = 1; end
            if (r[i] < I32Min) begin r[i] = I32Min; sat = 1; end
        end
        res.x = r[0][31:0];
        res.y = r[1][31:0];
        res.z = r[2][31:0];
        res.status = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    assign o_pending = expected_coords.size();

    always @(posedge i_clk) begin
        t_coord want;
        if (!i_rst_n) begin
            pose_rot[0] = ROT_ONE;
            pose_rot[1] = '0; pose_rot[2] = '0; pose_rot[3] = '0;
            pose_shift[0] = '0; pose_shift[1] = '0; pose_shift[2] = '0;
            expected_coords.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROT_W:   pose_rot[0] = i_cfg_data;
                    REG_ROT_X:   pose_rot[1] = i_cfg_data;
                    REG_ROT_Y:   pose_rot[2] = i_cfg_data;
                    REG_ROT_Z:   pose_rot[3] = i_cfg_data;
                    REG_SHIFT_X: pose_shift[0] = i_cfg_data;
                    REG_SHIFT_Y: pose_shift[1] = i_cfg_data;
                    REG_SHIFT_Z: pose_shift[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_coords.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    want = expected_coords.pop_front();
                    if (i_out_x !== want.x) begin
                        $error("out_x expected %0d actual %0d", want.x, i_out_x);
                        o_fail_count++;
                    end
                    if (i_out_y !== want.y) begin
                        $error("out_y expected %0d actual %0d", want.y, i_out_y);
                        o_fail_count++;
                    end
                    if (i_out_z !== want.z) begin
                        $error("out_z expected %0d actual %0d", want.z, i_out_z);
                        o_fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, i_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_coords.push_back(transform_beat(i_req_type, i_in_x, i_in_y, i_in_z));
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives poses and coordinate beats into the pose transform with random
// idling on both sides; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import qpt_pkg::*;

    localparam int CycleLimit = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    logic [CoordW-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_req_type;
    logic signed [CoordW-1:0] i_in_x, i_in_y, i_in_z;
    logic              o_valid;
    logic              i_stall;
    logic signed [CoordW-1:0] o_out_x, o_out_y, o_out_z;
    logic [1:0]        o_status;
    int                fail_count;
    int                pending;
    bit                calm = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_taken;

    quaternion_pose_point_transform u_dut (.*);

    pose_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_req_type(i_req_type),
        .i_in_x(i_in_x), .i_in_y(i_in_y), .i_in_z(i_in_z),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_x(o_out_x), .i_out_y(o_out_y), .i_out_z(o_out_z),
        .i_status(o_status), .o_fail_count(fail_count), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    // receiver: random hold-offs, one long one on request
    initial begin
        i_stall = 0;
        hold_taken = 0;
        @(posedge i_clk);
        forever begin
            if (calm) begin
                i_stall <= 0;
                @(posedge i_clk);
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1;
                i_stall <= 1;
                repeat (80) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0);
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        for (int cyc = 0; cyc < CycleLimit; cyc++) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
            3, 4: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 22)
                                             : -$urandom_range(0, 1 << 22);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= kind; i_in_x <= x; i_in_y <= y; i_in_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_pose(logic [31:0] w, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [31:0] tx, logic [31:0] ty,
                              logic [31:0] tz);
        logic [31:0] vals [7];
        vals = '{w, x, y, z, tx, ty, tz};
        for (int i = 0; i < NumRegs; i++) begin
            i_cfg_we <= 1; i_cfg_idx <= i[2:0]; i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    task automatic random_beats(int count);
        for (int i = 0; i < count; i++)
            send_beat(2'($urandom_range(0, 3)), pick_coord(), pick_coord(), pick_coord());
    endtask

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 0; i_req_type = REQ_PT_WORLD;
        i_in_x = '0; i_in_y = '0; i_in_z = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset pose: identity, every request kind at the extremes
        send_beat(REQ_PT_WORLD, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        send_beat(REQ_VEC_WORLD, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_beat(REQ_PT_SENSOR, 32'h0, 32'h0, 32'h0);
        send_beat(REQ_VEC_SENSOR, 32'h1234_5678, 32'hedcb_a988, 32'h7fff_ffff);
        drain();

        // extreme translation forces saturation
        write_pose(ROT_ONE, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        send_beat(REQ_PT_WORLD, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_beat(REQ_PT_SENSOR, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        send_beat(REQ_VEC_WORLD, 32'h7fff_ffff, 32'h8000_0000, 32'h5);
        drain();

        // 90 degrees about z (unnormalised)
        write_pose(32'h2000_0000, 0, 0, 32'h2000_0000, 32'h0003_0000, 0, 32'hfffe_0000);
        send_beat(REQ_PT_WORLD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_beat(REQ_PT_SENSOR, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        drain();

        // near-zero rotation just under the threshold
        write_pose(32'd1000, 32'd100, 32'hffff_ff9c, 32'd50, 32'h0001_0000, 0, 0);
        send_beat(REQ_PT_WORLD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_beat(REQ_VEC_SENSOR, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
        drain();

        // all-zero rotation
        write_pose(0, 0, 0, 0, 0, 0, 0);
        send_beat(REQ_PT_SENSOR, 32'h0001_0000, 32'h0, 32'h0);
        drain();

        // tiny rotation exactly at the threshold is still valid
        write_pose(32'd1024, 0, 0, 0, 0, 0, 0);
        send_beat(REQ_VEC_WORLD, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff);
        drain();

        write_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_beat(REQ_PT_WORLD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_beat(REQ_PT_SENSOR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        drain();

        write_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_beat(REQ_PT_WORLD, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_beat(REQ_PT_SENSOR, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        drain();

        // random poses, the last phase without idling
        for (int ph = 0; ph < 6; ph++) begin
            if ($urandom_range(0, 4) == 0)
                write_pose($urandom_range(0, 2000), $urandom_range(0, 300),
                           $urandom_range(0, 300), $urandom_range(0, 300),
                           pick_coord(), pick_coord(), pick_coord());
            else
                write_pose($urandom, $urandom, $urandom, $urandom,
                           pick_coord(), pick_coord(), pick_coord());
            if (ph == 1) hold_req = 1;
            if (ph == 5) calm = 1;
            random_beats(155);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- quaternion_pose_point_transform.f -----
design/qpt_pkg.sv
design/qpt_pose.sv
design/quaternion_pose_point_transform.sv
design/qpt_checker.sv
tb/pose_checker.sv
tb/tb_top.sv
